/* hw/rtl/plb_pkg.sv */
`timescale 1ns / 1ps

package plb_pkg;

  // Default sizes of the book.
  localparam int unsigned BOOK_DEPTH_DEF = 5;
  localparam int unsigned NUM_SEC_DEF    = 16;
  // Most swept-level prints that one trade reports before its final print.
  localparam int unsigned MAX_PRINTS     = 5;

  localparam logic signed [31:0] INVALID_PRICE = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_SIZE      = 32'sh7fff_ffff;

  // Function codes.
  localparam logic [1:0] FUNC_NEW    = 2'd0;
  localparam logic [1:0] FUNC_CHANGE = 2'd1;
  localparam logic [1:0] FUNC_TRADE  = 2'd2;

  // Side codes; any other code is taken as no information.
  localparam logic [1:0] SIDE_BUY  = 2'd0;
  localparam logic [1:0] SIDE_SELL = 2'd1;
  localparam logic [1:0] SIDE_NONE = 2'd2;

  // Notification codes.
  localparam logic [2:0] NTF_NONE  = 3'd0;
  localparam logic [2:0] NTF_L1P   = 3'd1;
  localparam logic [2:0] NTF_L1S   = 3'd2;
  localparam logic [2:0] NTF_L2    = 3'd3;
  localparam logic [2:0] NTF_PRINT = 3'd4;

  // Bit positions of the per-security change flags.
  localparam int unsigned FL_L1P   = 0;
  localparam int unsigned FL_L1S   = 1;
  localparam int unsigned FL_DEEP  = 2;
  localparam int unsigned FL_READY = 3;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         security;
    logic [1:0]         side;
    logic [3:0]         level;
    logic signed [31:0] price;
    logic [30:0]        size;
    logic [15:0]        order_count;
    logic               intermediate;
  } item_t;

  typedef struct packed {
    logic [2:0]         notify;
    logic               deep_changed;
    logic               book_ready;
    logic signed [31:0] best_bid_price;
    logic signed [31:0] best_bid_size;
    logic [15:0]        best_bid_orders;
    logic signed [31:0] best_ask_price;
    logic signed [31:0] best_ask_size;
    logic [15:0]        best_ask_orders;
    logic signed [31:0] print_price;
    logic [30:0]        print_size;
    logic               last;
  } result_t;

  typedef struct packed {
    logic signed [31:0] price;
    logic [30:0]        size;
    logic [15:0]        orders;
  } level_t;

  typedef struct packed {
    logic signed [31:0] price;
    logic signed [31:0] size;
    logic [15:0]        orders;
  } best_t;

  typedef struct packed {
    logic signed [31:0] price;
    logic signed [31:0] size;
  } expect_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       rd;
    logic       ld;
    logic       q1;
    logic       q2;
    logic       ts;
    logic       tf;
    logic       wr;
    logic       emit;
    logic [2:0] emit_idx;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sec_ok;
    logic is_trade;
    logic is_quote;
    logic scan_done;
    logic emit_last;
  } ctl_sts_t;

endpackage

/* hw/rtl/plb_ctrl.sv */
`timescale 1ns / 1ps

module plb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  plb_pkg::ctl_sts_t sts_i,
  output plb_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_LD   = 9'b000000100,
    S_Q1   = 9'b000001000,
    S_Q2   = 9'b000010000,
    S_TS   = 9'b000100000,
    S_TF   = 9'b001000000,
    S_WR   = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] emit_idx_q, emit_idx_d;

  // Next state, emit counter and command decode.
  always_comb begin
    state_d    = state_q;
    emit_idx_d = emit_idx_q;
    cmd_o      = '0;
    cmd_o.emit_idx = emit_idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_LD;
      end
      S_LD: begin
        cmd_o.ld = 1'b1;
        if (!sts_i.sec_ok || (!sts_i.is_trade && !sts_i.is_quote)) begin
          state_d = S_EMIT;
        end else if (sts_i.is_trade) begin
          state_d = S_TS;
        end else begin
          state_d = S_Q1;
        end
      end
      S_Q1: begin
        cmd_o.q1 = 1'b1;
        state_d  = S_Q2;
      end
      S_Q2: begin
        cmd_o.q2 = 1'b1;
        state_d  = S_WR;
      end
      S_TS: begin
        cmd_o.ts = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_TF;
        end
      end
      S_TF: begin
        cmd_o.tf = 1'b1;
        state_d  = S_WR;
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_last) begin
          emit_idx_d = '0;
          state_d    = S_IDLE;
        end else begin
          emit_idx_d = 3'(emit_idx_q + 3'd1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      emit_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      emit_idx_q <= emit_idx_d;
    end
  end

  // An accepted item always starts with a read of its security's row.
  a_accept_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start) |=> state_q == S_RD)
    else $error("accepted item did not start a read");

  // The final beat of an item returns the controller to idle.
  a_last_idles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && sts_i.emit_last) |=> (state_q == S_IDLE && emit_idx_q == 3'd0))
    else $error("controller did not return to idle after the final beat");

  // No item produces more beats than the print limit plus its final beat.
  a_emit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (emit_idx_q <= 3'(plb_pkg::MAX_PRINTS)))
    else $error("too many result beats for one item");

endmodule

/* hw/rtl/plb_dp.sv */
`timescale 1ns / 1ps

module plb_dp #(
  parameter int unsigned BOOK_DEPTH     = plb_pkg::BOOK_DEPTH_DEF,
  parameter int unsigned NUM_SECURITIES = plb_pkg::NUM_SEC_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plb_pkg::item_t    item_i,
  input  plb_pkg::ctl_cmd_t cmd_i,
  output plb_pkg::ctl_sts_t sts_o,
  output logic              res_valid_o,
  output plb_pkg::result_t  res_o
);

  localparam int unsigned IW = $clog2(BOOK_DEPTH);
  localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);
  localparam int unsigned SW = (NUM_SECURITIES > 1) ? $clog2(NUM_SECURITIES) : 1;

  // One row holds all state of one security.
  typedef struct packed {
    plb_pkg::level_t  [1:0][BOOK_DEPTH-1:0] lv;
    plb_pkg::best_t   [1:0]                 best;
    logic             [1:0]                 pend;
    plb_pkg::expect_t [1:0]                 expc;
    logic             [3:0]                 flags;
  } row_t;

  function automatic logic thru_f(logic buy, logic signed [31:0] a, logic signed [31:0] b);
    return buy ? (a <= b) : (a >= b);
  endfunction

  function automatic logic beyond_f(logic buy, logic signed [31:0] a, logic signed [31:0] b);
    return buy ? (a < b) : (a > b);
  endfunction

  function automatic plb_pkg::best_t to_best(plb_pkg::level_t l);
    plb_pkg::best_t b;
    b.price  = l.price;
    b.size   = $signed({1'b0, l.size});
    b.orders = l.orders;
    return b;
  endfunction

  function automatic plb_pkg::level_t clr_level();
    plb_pkg::level_t l;
    l.price  = plb_pkg::INVALID_PRICE;
    l.size   = '0;
    l.orders = '0;
    return l;
  endfunction

  function automatic row_t reset_row();
    row_t r;
    r = '0;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < BOOK_DEPTH; k++) begin
        r.lv[s][k] = clr_level();
      end
      r.best[s].price = plb_pkg::INVALID_PRICE;
    end
    r.pend = plb_pkg::SIDE_NONE;
    return r;
  endfunction

  row_t                  mem [NUM_SECURITIES];
  logic [NUM_SECURITIES-1:0] vld_q;
  row_t                  rd_q;
  logic                  rd_vld_q;
  row_t                  wk_q, wk_d;
  plb_pkg::item_t        item_q;
  logic [1:0]            side_q;
  logic signed [31:0]    p_q, p_d;
  logic                  abort_q, abort_d;
  logic [CW-1:0]         i_q, i_d;
  logic signed [36:0]    sd_q, sd_d;
  logic [2:0]            note_q, note_d;
  logic                  deep_q, deep_d;
  logic signed [31:0]    pp_q, pp_d;
  logic [30:0]           ps_q, ps_d;
  logic [2:0]            np_q, np_d;
  plb_pkg::result_t      res_q, res_d;
  logic                  res_valid_q;

  logic [SW-1:0]         addr;
  logic                  sec_ok;
  logic                  buy, s_i, o_i, side_ok;
  logic                  eob, in_rng;
  logic [IW-1:0]         idx;
  plb_pkg::level_t [BOOK_DEPTH-1:0] lvo;
  plb_pkg::level_t       lvo_i;
  logic                  scan_cond;

  // Decode of the captured item.
  assign addr    = SW'(item_q.security);
  assign sec_ok  = (32'(item_q.security) < NUM_SECURITIES);
  assign buy     = (side_q == plb_pkg::SIDE_BUY);
  assign s_i     = (side_q == plb_pkg::SIDE_SELL);
  assign o_i     = ~s_i;
  assign side_ok = (side_q != plb_pkg::SIDE_NONE);
  assign eob     = (item_q.price == 32'sd0) && (item_q.size == '0) && (item_q.order_count == '0);
  assign in_rng  = (item_q.level != 4'd0) && (32'(item_q.level) <= BOOK_DEPTH);
  assign idx     = IW'(item_q.level - 4'd1);
  assign lvo     = wk_q.lv[o_i];
  assign lvo_i   = lvo[IW'(i_q)];

  // One step of the trade sweep: the level at i is passed through by the trade.
  assign scan_cond = side_ok && (32'(i_q) < BOOK_DEPTH) && (lvo_i.size != '0) &&
                     beyond_f(buy, lvo_i.price, item_q.price);

  assign sts_o.sec_ok    = sec_ok;
  assign sts_o.is_trade  = (item_q.func == plb_pkg::FUNC_TRADE);
  assign sts_o.is_quote  = (item_q.func == plb_pkg::FUNC_NEW) ||
                           (item_q.func == plb_pkg::FUNC_CHANGE);
  assign sts_o.scan_done = !scan_cond;
  assign sts_o.emit_last = (cmd_i.emit_idx == np_q);

  // Book memory, one row per security.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && sec_ok) begin
      mem[addr] <= wk_q;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[addr];
    end
  end

  // Row valid bits; a row never written reads as the reset book.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr && sec_ok) begin
        vld_q[addr] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rd_vld_q <= sec_ok && vld_q[addr];
      end
    end
  end

  // Working copy update for every step of an item.
  always_comb begin
    plb_pkg::level_t                  old_lv;
    plb_pkg::level_t [BOOK_DEPTH-1:0] shifted;
    plb_pkg::level_t                  lvi, lvi1;
    logic signed [31:0]               p;
    logic [15:0]                      cnt_e;
    logic [3:0]                       f;
    logic                             cross0, early, ready, i_ok, i1_ok, final_ok;
    logic [CW-1:0]                    ncross;
    logic [BOOK_DEPTH-1:0]            cr;
    logic signed [36:0]               diff, szi;
    logic [30:0]                      ps;

    wk_d    = wk_q;
    p_d     = p_q;
    abort_d = abort_q;
    i_d     = i_q;
    sd_d    = sd_q;
    note_d  = note_q;
    deep_d  = deep_q;
    pp_d    = pp_q;
    ps_d    = ps_q;
    np_d    = np_q;

    old_lv  = wk_q.lv[s_i][idx];
    p       = (item_q.price == 32'sd0) ? old_lv.price : item_q.price;
    cnt_e   = (item_q.func == plb_pkg::FUNC_CHANGE && item_q.order_count == '0) ?
              old_lv.orders : item_q.order_count;
    f       = wk_q.flags;
    early   = 1'b0;
    ready   = wk_q.flags[plb_pkg::FL_READY];
    final_ok = 1'b0;
    ps      = item_q.size;

    // Crossed levels on the other side: leading levels at or through p with size.
    cross0 = thru_f(buy, lvo[0].price, p_q);
    for (int k = 0; k < BOOK_DEPTH; k++) begin
      cr[k] = thru_f(buy, lvo[k].price, p_q) && (lvo[k].size != '0);
    end
    ncross = CW'(BOOK_DEPTH);
    for (int k = BOOK_DEPTH - 1; k >= 0; k--) begin
      if (!cr[k]) begin
        ncross = CW'(k);
      end
    end
    for (int k = 0; k < BOOK_DEPTH; k++) begin
      if (k + 32'(ncross) < BOOK_DEPTH) begin
        shifted[k] = lvo[IW'(k + 32'(ncross))];
      end else begin
        shifted[k] = clr_level();
      end
    end

    // Sweep outcome operands.
    i_ok  = (32'(i_q) < BOOK_DEPTH) && (lvo_i.size != '0);
    lvi   = lvo_i;
    lvi1  = lvo[IW'(32'(i_q) + 1)];
    i1_ok = (32'(i_q) + 1 < BOOK_DEPTH) && (lvi1.size != '0);
    szi   = $signed({6'b0, lvi.size});
    diff  = szi - sd_q;

    // Load the row and reset the per-item registers.
    if (cmd_i.ld) begin
      wk_d    = rd_vld_q ? rd_q : reset_row();
      deep_d  = rd_vld_q ? rd_q.flags[plb_pkg::FL_DEEP] : 1'b0;
      note_d  = plb_pkg::NTF_NONE;
      pp_d    = '0;
      ps_d    = '0;
      np_d    = '0;
      abort_d = 1'b0;
      i_d     = '0;
      sd_d    = $signed(37'(item_q.size));
    end

    // First quote step: write the addressed level, or clear it and all deeper levels.
    if (cmd_i.q1) begin
      if (eob) begin
        if (side_ok && in_rng) begin
          for (int k = 0; k < BOOK_DEPTH; k++) begin
            if (k >= 32'(idx)) begin
              wk_d.lv[s_i][k] = clr_level();
            end
          end
        end
        wk_d.flags[plb_pkg::FL_DEEP] = 1'b1;
      end else if (side_ok) begin
        if (!in_rng) begin
          abort_d = 1'b1;
        end else begin
          if (idx == '0 &&
              wk_q.pend == (buy ? plb_pkg::SIDE_SELL : plb_pkg::SIDE_BUY) &&
              ((wk_q.expc[s_i].price == p &&
                $signed({1'b0, item_q.size}) <= wk_q.expc[s_i].size) ||
               beyond_f(!buy, wk_q.expc[s_i].price, p))) begin
            wk_d.pend = plb_pkg::SIDE_NONE;
          end
          wk_d.lv[s_i][idx].price  = p;
          wk_d.lv[s_i][idx].size   = item_q.size;
          wk_d.lv[s_i][idx].orders = cnt_e;
          if (idx == '0) begin
            if (old_lv.price != p) begin
              wk_d.flags[plb_pkg::FL_L1P] = 1'b1;
            end else if (old_lv.size != item_q.size) begin
              wk_d.flags[plb_pkg::FL_L1S] = 1'b1;
            end
          end else begin
            wk_d.flags[plb_pkg::FL_DEEP] = 1'b1;
          end
          p_d = p;
        end
      end
    end

    // Second quote step: remove crossed levels, refresh bests, notify.
    if (cmd_i.q2 && !abort_q) begin
      if (side_ok && !eob && in_rng) begin
        if (cross0 && lvo[0].size == '0) begin
          f[plb_pkg::FL_READY] = 1'b0;
        end else begin
          if (cross0) begin
            wk_d.lv[o_i] = shifted;
            if (shifted[0].size == '0) begin
              early = 1'b1;
              f[plb_pkg::FL_READY] = 1'b0;
            end else begin
              wk_d.best[o_i] = to_best(shifted[0]);
              f[plb_pkg::FL_L1P] = 1'b1;
            end
          end
          if (!early && (f[plb_pkg::FL_L1P] || f[plb_pkg::FL_L1S])) begin
            wk_d.best[s_i] = to_best(wk_q.lv[s_i][0]);
          end
        end
      end
      if (early) begin
        note_d = plb_pkg::NTF_NONE;
        deep_d = f[plb_pkg::FL_DEEP];
      end else begin
        if (!f[plb_pkg::FL_READY] && wk_d.lv[0][0].size != '0 &&
            wk_d.lv[1][0].size != '0) begin
          f[plb_pkg::FL_READY] = 1'b1;
        end
        deep_d = f[plb_pkg::FL_DEEP];
        if (!f[plb_pkg::FL_READY] || item_q.intermediate ||
            wk_q.pend != plb_pkg::SIDE_NONE) begin
          note_d = plb_pkg::NTF_NONE;
        end else begin
          if (f[plb_pkg::FL_L1P]) begin
            note_d = plb_pkg::NTF_L1P;
            f[plb_pkg::FL_L1P] = 1'b0;
            f[plb_pkg::FL_L1S] = 1'b0;
          end else if (f[plb_pkg::FL_L1S]) begin
            note_d = plb_pkg::NTF_L1S;
            f[plb_pkg::FL_L1S] = 1'b0;
          end else begin
            note_d = plb_pkg::NTF_L2;
          end
          f[plb_pkg::FL_DEEP] = 1'b0;
        end
      end
      wk_d.flags = f;
    end

    // Trade sweep: one level per cycle, subtracting each swept size.
    if (cmd_i.ts && scan_cond) begin
      i_d  = CW'(i_q + 1'b1);
      sd_d = sd_q - $signed({6'b0, lvo_i.size});
    end

    // Trade finish: mask the best of the side hit and set up the prints.
    if (cmd_i.tf) begin
      wk_d.pend = side_q;
      if (wk_q.best[0].price != plb_pkg::INVALID_PRICE &&
          wk_q.best[1].price != plb_pkg::INVALID_PRICE) begin
        if (!side_ok || beyond_f(buy, item_q.price, lvo[0].price)) begin
          final_ok = 1'b1;
        end else if (item_q.price == lvo[0].price) begin
          final_ok = 1'b1;
          if (item_q.size >= lvo[0].size) begin
            wk_d.best[o_i] = to_best(lvo[1]);
          end else begin
            wk_d.best[o_i]      = to_best(lvo[0]);
            wk_d.best[o_i].size = $signed({1'b0, 31'(lvo[0].size - item_q.size)});
          end
          wk_d.expc[o_i].price = wk_d.best[o_i].price;
          wk_d.expc[o_i].size  = wk_d.best[o_i].size;
        end else if (!(lvo[BOOK_DEPTH-1].size != '0 &&
                       beyond_f(buy, lvo[BOOK_DEPTH-1].price, item_q.price)) &&
                     i_ok && (sd_q < szi || i1_ok)) begin
          final_ok = 1'b1;
          if (sd_q >= szi) begin
            wk_d.best[o_i] = to_best(lvi1);
          end else begin
            wk_d.best[o_i] = to_best(lvi);
            wk_d.best[o_i].size = (diff > 37'sd2147483647) ? plb_pkg::MAX_SIZE :
                                  32'(diff);
          end
          wk_d.expc[o_i].price = wk_d.best[o_i].price;
          wk_d.expc[o_i].size  = wk_d.best[o_i].size;
          if (ready) begin
            np_d = (32'(i_q) > plb_pkg::MAX_PRINTS) ? 3'(plb_pkg::MAX_PRINTS) : 3'(i_q);
          end
          ps = (sd_q < 37'sd1) ? 31'd1 : 31'(sd_q);
        end
      end
      if (final_ok && ready) begin
        note_d = plb_pkg::NTF_PRINT;
        pp_d   = item_q.price;
        ps_d   = ps;
      end
    end
  end

  // Result beat: swept-level prints first, then the final result.
  always_comb begin
    plb_pkg::level_t lj;
    lj    = lvo[IW'(cmd_i.emit_idx)];
    res_d = '0;
    if (sec_ok) begin
      res_d.deep_changed    = deep_q;
      res_d.book_ready      = wk_q.flags[plb_pkg::FL_READY];
      res_d.best_bid_price  = wk_q.best[0].price;
      res_d.best_bid_size   = wk_q.best[0].size;
      res_d.best_bid_orders = wk_q.best[0].orders;
      res_d.best_ask_price  = wk_q.best[1].price;
      res_d.best_ask_size   = wk_q.best[1].size;
      res_d.best_ask_orders = wk_q.best[1].orders;
      if (cmd_i.emit_idx < np_q) begin
        res_d.notify      = plb_pkg::NTF_PRINT;
        res_d.print_price = lj.price;
        res_d.print_size  = lj.size;
      end else begin
        res_d.notify      = note_q;
        res_d.print_price = pp_q;
        res_d.print_size  = ps_q;
      end
    end
    res_d.last = (cmd_i.emit_idx == np_q);
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    wk_q  <= wk_d;
    p_q   <= p_d;
    i_q   <= i_d;
    sd_q  <= sd_d;
    pp_q  <= pp_d;
    ps_q  <= ps_d;
    res_q <= res_d;
    if (cmd_i.capture) begin
      item_q <= item_i;
      side_q <= (item_i.side == plb_pkg::SIDE_BUY || item_i.side == plb_pkg::SIDE_SELL) ?
                item_i.side : plb_pkg::SIDE_NONE;
    end
  end

  // Control registers of the item in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abort_q     <= 1'b0;
      note_q      <= plb_pkg::NTF_NONE;
      deep_q      <= 1'b0;
      np_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      abort_q     <= abort_d;
      note_q      <= note_d;
      deep_q      <= deep_d;
      np_q        <= np_d;
      res_valid_q <= cmd_i.emit;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* hw/rtl/price_level_book_update.sv */
`timescale 1ns / 1ps
// A level update gives one result beat. A trade sweeps the levels one per cycle and gives
// up to 6 result beats: its swept-level prints, then its final beat. A new item is taken
// only while busy is low, once the last beat of the previous item has been issued.
// Reset clears the controller and the per-security row valid bits; every book then
// reads as empty, with no clearing pass. The receiver cannot stall result beats.
module price_level_book_update #(
  parameter int unsigned BOOK_DEPTH     = plb_pkg::BOOK_DEPTH_DEF,
  parameter int unsigned NUM_SECURITIES = plb_pkg::NUM_SEC_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  plb_pkg::item_t   item_i,
  output logic             res_valid_o,
  output plb_pkg::result_t res_o
);

  plb_pkg::ctl_cmd_t cmd;
  plb_pkg::ctl_sts_t sts;

  // Sequencer.
  plb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Book storage and update logic.
  plb_dp #(
    .BOOK_DEPTH     (BOOK_DEPTH),
    .NUM_SECURITIES (NUM_SECURITIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

/* tb/sv/plb_book_checker.sv */
`timescale 1ns / 1ps

module plb_book_checker
  import plb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    busy_i,
  input  item_t   item_i,
  input  logic    res_valid_i,
  input  result_t res_i,
  output int      errors_o,
  output int      pending_o
);

  localparam int DEPTH = 5;
  localparam int NSEC  = 16;
  // Index of each book side in the shadow arrays.
  localparam int BID = 0;
  localparam int ASK = 1;

  // Shadow copy of every book, best store and flag set.
  int          lvl_px  [NSEC][2][DEPTH];
  int          lvl_qty [NSEC][2][DEPTH];
  logic [15:0] lvl_ord [NSEC][2][DEPTH];
  int          top_px  [NSEC][2];
  int          top_qty [NSEC][2];
  logic [15:0] top_ord [NSEC][2];
  int          want_px [NSEC][2];
  int          want_qty[NSEC][2];
  logic [1:0]  trade_side[NSEC];
  logic [3:0]  flags[NSEC];

  result_t beats_due[$];
  int      errors;

  assign errors_o  = errors;
  assign pending_o = beats_due.size();

  function automatic bit at_or_past(bit buy, int a, int b);
    return buy ? (a <= b) : (a >= b);
  endfunction

  function automatic bit past(bit buy, int a, int b);
    return buy ? (a < b) : (a > b);
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic void wipe_level(int sec, int sd, int i);
    lvl_px[sec][sd][i]  = INVALID_PRICE;
    lvl_qty[sec][sd][i] = 0;
    lvl_ord[sec][sd][i] = '0;
  endfunction

  function automatic void take_top(int sec, int sd, int i);
    top_px[sec][sd]  = lvl_px[sec][sd][i];
    top_qty[sec][sd] = lvl_qty[sec][sd][i];
    top_ord[sec][sd] = lvl_ord[sec][sd][i];
  endfunction

  function automatic void reset_books();
    for (int s = 0; s < NSEC; s++) begin
      for (int d = 0; d < 2; d++) begin
        for (int i = 0; i < DEPTH; i++) wipe_level(s, d, i);
        top_px[s][d]   = INVALID_PRICE;
        top_qty[s][d]  = 0;
        top_ord[s][d]  = '0;
        want_px[s][d]  = 0;
        want_qty[s][d] = 0;
      end
      trade_side[s] = SIDE_NONE;
      flags[s]      = '0;
    end
  endfunction

  // Queues one expected beat built from the current view of the book.
  function automatic void push_beat(int sec, logic [2:0] ntf, bit deep, int pp, longint ps);
    result_t r;
    r.notify          = ntf;
    r.deep_changed    = deep;
    r.book_ready      = flags[sec][FL_READY];
    r.best_bid_price  = top_px[sec][BID];
    r.best_bid_size   = top_qty[sec][BID];
    r.best_bid_orders = top_ord[sec][BID];
    r.best_ask_price  = top_px[sec][ASK];
    r.best_ask_size   = top_qty[sec][ASK];
    r.best_ask_orders = top_ord[sec][ASK];
    r.print_price     = pp;
    r.print_size      = ps[30:0];
    r.last            = 1'b0;
    beats_due.push_back(r);
  endfunction

  // Level update or end of book; returns the notification code.
  function automatic logic [2:0] apply_quote(int sec, logic [1:0] side, int level, int price,
                                             int size, logic [15:0] cnt, bit inter,
                                             output bit deep);
    logic [3:0] f;
    bit         in_book, buy;
    int         own, opp, idx, old_qty, old_px, p, n;
    logic [2:0] ntf;
    f       = flags[sec];
    in_book = level >= 1 && level <= DEPTH;
    deep    = f[FL_DEEP];
    if (price == 0 && size == 0 && cnt == 0) begin
      if (side < 2 && in_book) begin
        own = (side == SIDE_BUY) ? BID : ASK;
        for (int i = level - 1; i < DEPTH; i++) wipe_level(sec, own, i);
      end
      f[FL_DEEP] = 1'b1;
    end else if (side < 2) begin
      buy = side == SIDE_BUY;
      own = buy ? BID : ASK;
      opp = buy ? ASK : BID;
      if (!in_book) return NTF_NONE;
      idx     = level - 1;
      old_qty = lvl_qty[sec][own][idx];
      old_px  = lvl_px[sec][own][idx];
      p       = (price == 0) ? old_px : price;
      // A level-1 update that meets the expected best releases held quotes.
      if (idx == 0 && trade_side[sec] == (buy ? SIDE_SELL : SIDE_BUY) &&
          ((want_px[sec][own] == p && size <= want_qty[sec][own]) ||
           past(!buy, want_px[sec][own], p)))
        trade_side[sec] = SIDE_NONE;
      lvl_qty[sec][own][idx] = size;
      lvl_ord[sec][own][idx] = cnt;
      lvl_px[sec][own][idx]  = p;
      if (idx == 0) begin
        if (old_px != p) f[FL_L1P] = 1'b1;
        else if (old_qty != size) f[FL_L1S] = 1'b1;
      end else begin
        f[FL_DEEP] = 1'b1;
      end
      if (at_or_past(buy, lvl_px[sec][opp][0], p) && lvl_qty[sec][opp][0] <= 0) begin
        f[FL_READY] = 1'b0;
      end else begin
        // Remove crossed levels on the opposite side by shifting the rest up.
        if (at_or_past(buy, lvl_px[sec][opp][0], p)) begin
          n = 0;
          while (n < DEPTH && at_or_past(buy, lvl_px[sec][opp][n], p) &&
                 lvl_qty[sec][opp][n] > 0)
            n++;
          for (int k = 0; k < DEPTH; k++) begin
            if (k + n < DEPTH) begin
              lvl_px[sec][opp][k]  = lvl_px[sec][opp][k+n];
              lvl_qty[sec][opp][k] = lvl_qty[sec][opp][k+n];
              lvl_ord[sec][opp][k] = lvl_ord[sec][opp][k+n];
            end else begin
              wipe_level(sec, opp, k);
            end
          end
          if (n >= DEPTH || lvl_qty[sec][opp][0] <= 0) begin
            f[FL_READY] = 1'b0;
            flags[sec]  = f;
            deep        = f[FL_DEEP];
            return NTF_NONE;
          end
          take_top(sec, opp, 0);
          f[FL_L1P] = 1'b1;
        end
        if (f[FL_L1P] || f[FL_L1S]) take_top(sec, own, 0);
      end
    end
    if (!f[FL_READY] && lvl_qty[sec][BID][0] > 0 && lvl_qty[sec][ASK][0] > 0)
      f[FL_READY] = 1'b1;
    deep = f[FL_DEEP];
    if (!f[FL_READY] || inter || trade_side[sec] != SIDE_NONE) begin
      flags[sec] = f;
      return NTF_NONE;
    end
    if (f[FL_L1P]) begin
      ntf = NTF_L1P;
      f[FL_L1P] = 1'b0;
      f[FL_L1S] = 1'b0;
    end else if (f[FL_L1S]) begin
      ntf = NTF_L1S;
      f[FL_L1S] = 1'b0;
    end else begin
      ntf = NTF_L2;
    end
    f[FL_DEEP] = 1'b0;
    flags[sec] = f;
    return ntf;
  endfunction

  // Trade: masks the hit side, queues the prints and returns how many were queued.
  function automatic int apply_trade(int sec, logic [1:0] side, int tp, int tq);
    bit     ready, deep, buy;
    int     n, opp, i;
    longint ps, left;
    ready = flags[sec][FL_READY];
    deep  = flags[sec][FL_DEEP];
    n     = 0;
    ps    = tq;
    trade_side[sec] = side;
    if (top_px[sec][BID] <= INVALID_PRICE || top_px[sec][ASK] <= INVALID_PRICE) return 0;
    if (side < 2) begin
      buy = side == SIDE_BUY;
      opp = buy ? ASK : BID;
      if (past(buy, tp, lvl_px[sec][opp][0])) begin
        // Inside the spread: the book is left as it is.
      end else if (tp == lvl_px[sec][opp][0]) begin
        if (tq >= lvl_qty[sec][opp][0]) begin
          take_top(sec, opp, 1);
        end else begin
          take_top(sec, opp, 0);
          top_qty[sec][opp] = lvl_qty[sec][opp][0] - tq;
        end
        want_px[sec][opp]  = top_px[sec][opp];
        want_qty[sec][opp] = top_qty[sec][opp];
      end else begin
        left = tq;
        if (lvl_qty[sec][opp][DEPTH-1] > 0 && past(buy, lvl_px[sec][opp][DEPTH-1], tp))
          return 0;
        i = 0;
        while (i < DEPTH && lvl_qty[sec][opp][i] > 0 && past(buy, lvl_px[sec][opp][i], tp)) begin
          left -= lvl_qty[sec][opp][i];
          i++;
        end
        if (i >= DEPTH) return 0;
        if (lvl_qty[sec][opp][i] <= 0) return 0;
        if (left >= lvl_qty[sec][opp][i]) begin
          if (i + 1 >= DEPTH) return 0;
          if (lvl_qty[sec][opp][i+1] <= 0) return 0;
          take_top(sec, opp, i + 1);
        end else begin
          take_top(sec, opp, i);
          top_qty[sec][opp] = clip32(longint'(lvl_qty[sec][opp][i]) - left);
        end
        want_px[sec][opp]  = top_px[sec][opp];
        want_qty[sec][opp] = top_qty[sec][opp];
        if (ready)
          for (int j = 0; j < i && n < MAX_PRINTS; j++) begin
            push_beat(sec, NTF_PRINT, deep, lvl_px[sec][opp][j], lvl_qty[sec][opp][j]);
            n++;
          end
        ps = (left < 1) ? 1 : left;
      end
    end
    if (ready) begin
      push_beat(sec, NTF_PRINT, deep, tp, ps);
      n++;
    end
    return n;
  endfunction

  // Works out every beat that one accepted command causes.
  function automatic void predict_item(item_t it);
    int         sec, level, price, size, n;
    logic [1:0] side;
    logic [15:0] cnt;
    logic [2:0] ntf;
    bit         deep;
    sec   = it.security;
    side  = (it.side == 2'd3) ? SIDE_NONE : it.side;
    level = it.level;
    price = it.price;
    size  = int'({1'b0, it.size});
    cnt   = it.order_count;
    if (it.func == FUNC_TRADE) begin
      n = apply_trade(sec, side, price, size);
      if (n == 0) push_beat(sec, NTF_NONE, flags[sec][FL_DEEP], 0, 0);
    end else if (it.func == FUNC_NEW || it.func == FUNC_CHANGE) begin
      // A change fills a zero price or count from the stored level.
      if (it.func == FUNC_CHANGE && !(price == 0 && size == 0 && cnt == 0) && side < 2 &&
          level >= 1 && level <= DEPTH) begin
        if (price == 0) price = lvl_px[sec][(side == SIDE_BUY) ? BID : ASK][level-1];
        if (cnt == 0) cnt = lvl_ord[sec][(side == SIDE_BUY) ? BID : ASK][level-1];
      end
      ntf = apply_quote(sec, side, level, price, size, cnt, it.intermediate, deep);
      push_beat(sec, ntf, deep, 0, 0);
    end else begin
      push_beat(sec, NTF_NONE, flags[sec][FL_DEEP], 0, 0);
    end
    beats_due[$].last = 1'b1;
  endfunction

  task automatic report(string msg);
    $display("[%0t] check failed: %s", $realtime, msg);
    errors++;
  endtask

  task automatic cmp(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Compare each result beat with the oldest expectation, then record new commands.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t w;
    if (!rst_ni) begin
      reset_books();
      beats_due.delete();
      errors = 0;
    end else begin
      if (res_valid_i) begin
        if (beats_due.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          w = beats_due.pop_front();
          cmp("notify", res_i.notify, w.notify);
          cmp("deep_changed", res_i.deep_changed, w.deep_changed);
          cmp("book_ready", res_i.book_ready, w.book_ready);
          cmp("best_bid_price", res_i.best_bid_price, w.best_bid_price);
          cmp("best_bid_size", res_i.best_bid_size, w.best_bid_size);
          cmp("best_bid_orders", res_i.best_bid_orders, w.best_bid_orders);
          cmp("best_ask_price", res_i.best_ask_price, w.best_ask_price);
          cmp("best_ask_size", res_i.best_ask_size, w.best_ask_size);
          cmp("best_ask_orders", res_i.best_ask_orders, w.best_ask_orders);
          cmp("print_price", res_i.print_price, w.print_price);
          cmp("print_size", res_i.print_size, w.print_size);
          cmp("last", res_i.last, w.last);
        end
      end
      if (start_i && !busy_i) predict_item(item_i);
    end
  end

endmodule

/* tb/sv/tb_price_level_book_update.sv */
`timescale 1ns / 1ps

module tb_price_level_book_update;
  import plb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 240;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    res_valid_o;
  result_t res_o;
  int      errors;
  int      pending;
  int      cycles;
  bit      no_idle;

  price_level_book_update u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  plb_book_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .item_i     (item_i),
    .res_valid_i(res_valid_o),
    .res_i      (res_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic item_t cmd(logic [1:0] func, int sec, logic [1:0] side, int level,
                                int price, int size, int cnt, bit inter);
    item_t it;
    it.func         = func;
    it.security     = 4'(sec);
    it.side         = side;
    it.level        = 4'(level);
    it.price        = price;
    it.size         = 31'(size);
    it.order_count  = 16'(cnt);
    it.intermediate = inter;
    return it;
  endfunction

  // Presents one command after an idle gap and holds it until accepted.
  task automatic send(item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Mostly well-formed book traffic around a mid price, with some noise.
  function automatic item_t random_cmd();
    int          r, sec, lvl;
    logic [1:0]  side;
    item_t       it;
    r   = $urandom_range(0, 99);
    sec = $urandom_range(0, 3);
    lvl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
    side = 2'($urandom_range(0, 1));
    if (r < 55) begin
      it = cmd($urandom_range(0, 1) ? FUNC_CHANGE : FUNC_NEW, sec, side, lvl,
               (side == SIDE_BUY) ? 1000 - $urandom_range(0, 8) : 1000 + $urandom_range(0, 8),
               ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 100),
               ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 65535),
               $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) == 0) it.price = 0;
    end else if (r < 78) begin
      it = cmd(FUNC_TRADE, sec, 2'($urandom_range(0, 3)), lvl, 992 + $urandom_range(0, 16),
               $urandom_range(1, 300), 0, 0);
    end else if (r < 88) begin
      it = cmd($urandom_range(0, 1) ? FUNC_CHANGE : FUNC_NEW, sec, 2'($urandom_range(0, 3)),
               lvl, 0, 0, 0, 1'($urandom_range(0, 1)));
    end else begin
      it = cmd(2'($urandom_range(0, 3)), $urandom_range(0, 15), 2'($urandom_range(0, 3)),
               $urandom_range(0, 15), $urandom, $urandom, $urandom,
               1'($urandom_range(0, 1)));
    end
    return it;
  endfunction

  initial begin
    item_t dir[$];
    start   = 1'b0;
    item_i  = '0;
    rst_ni  = 1'b0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: build a book, then trades, crossings and edge cases.
    dir.push_back(cmd(FUNC_TRADE, 1, SIDE_BUY, 1, 1000, 5, 0, 0));
    dir.push_back(cmd(FUNC_NEW, 1, SIDE_BUY, 1, 1000, 10, 1, 0));
    dir.push_back(cmd(FUNC_NEW, 1, SIDE_BUY, 2, 999, 12, 2, 0));
    dir.push_back(cmd(FUNC_NEW, 1, SIDE_SELL, 1, 1002, 10, 3, 0));
    dir.push_back(cmd(FUNC_NEW, 1, SIDE_SELL, 2, 1003, 8, 4, 0));
    dir.push_back(cmd(FUNC_NEW, 1, SIDE_SELL, 3, 1004, 9, 5, 0));
    dir.push_back(cmd(FUNC_CHANGE, 1, SIDE_BUY, 1, 0, 20, 0, 0));
    dir.push_back(cmd(FUNC_CHANGE, 1, SIDE_BUY, 2, 998, 7, 3, 1));
    dir.push_back(cmd(FUNC_TRADE, 1, SIDE_BUY, 0, 1002, 5, 0, 0));
    dir.push_back(cmd(FUNC_CHANGE, 1, SIDE_SELL, 1, 1002, 5, 0, 0));
    dir.push_back(cmd(FUNC_TRADE, 1, SIDE_BUY, 0, 1004, 15, 0, 0));
    dir.push_back(cmd(FUNC_TRADE, 1, SIDE_NONE, 0, 1001, 4, 0, 0));
    dir.push_back(cmd(FUNC_TRADE, 1, SIDE_SELL, 0, 1001, 4, 0, 0));
    dir.push_back(cmd(FUNC_NEW, 1, SIDE_BUY, 1, 1003, 7, 1, 0));
    dir.push_back(cmd(FUNC_NEW, 1, SIDE_SELL, 2, 0, 0, 0, 0));
    dir.push_back(cmd(FUNC_NEW, 1, SIDE_SELL, 9, 0, 0, 0, 0));
    dir.push_back(cmd(FUNC_NEW, 1, SIDE_BUY, 0, 1000, 3, 1, 0));
    dir.push_back(cmd(FUNC_CHANGE, 1, SIDE_BUY, 15, 1000, 3, 1, 0));
    dir.push_back(cmd(2'd3, 1, SIDE_BUY, 1, 1000, 3, 1, 0));
    dir.push_back(cmd(FUNC_NEW, 1, 2'd3, 1, 1000, 3, 1, 0));
    dir.push_back(cmd(FUNC_NEW, 15, SIDE_SELL, 1, 32'sh7fff_ffff, 32'h7fff_ffff, 16'hffff, 0));
    dir.push_back(cmd(FUNC_NEW, 15, SIDE_BUY, 1, 32'sh8000_0001, 32'h7fff_ffff, 16'hffff, 0));
    dir.push_back(cmd(FUNC_TRADE, 15, SIDE_BUY, 0, 32'sh7fff_ffff, 32'h7fff_ffff, 0, 0));
    dir.push_back(cmd(FUNC_TRADE, 15, SIDE_SELL, 0, 32'sh8000_0000, 1, 0, 0));
    foreach (dir[i]) send(dir[i]);

    // Random traffic with bursts where the sender never idles.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) no_idle = 1'($urandom_range(0, 1));
      if (n == N_RANDOM / 2) begin
        start <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      send(random_cmd());
    end
    start <= 1'b0;

    // Drain the remaining beats and let the block settle.
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* price_level_book_update.f */
hw/rtl/plb_pkg.sv
hw/rtl/plb_ctrl.sv
hw/rtl/plb_dp.sv
hw/rtl/price_level_book_update.sv
tb/sv/plb_book_checker.sv
tb/sv/tb_price_level_book_update.sv
